// ===== rtl/ccker_pkg.sv =====
package ccker_pkg;

    localparam int BLOCKS_PER_REFILL_DEF = 16;
    localparam int DOUBLE_ROUNDS_DEF     = 4;
    localparam int REKEY_WORDS           = 10;
    localparam int CFG_IDX_W             = 3;

    // seed register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE      = 3'd4;

    localparam logic ACTION_RAW     = 1'b0;
    localparam logic ACTION_UNIFORM = 1'b1;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                         32'h79622d32, 32'h6b206574};

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FLOOR,
        S_DRAW,
        S_RDWAIT,
        S_MOD,
        S_BLK_INIT,
        S_ROUND,
        S_FINAL,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic seed;
        logic div_floor;
        logic div_word;
        logic floor_ld;
        logic value_zero;
        logic value_word;
        logic value_rem;
        logic out_ld;
        logic read_word;
        logic blk_init;
        logic round_step;
        logic final_add;
        logic write_word;
        logic next_block;
        logic rekey;
    } t_cmd;

    typedef struct packed {
        logic seeded;
        logic action;
        logic bound_small;
        logic words_empty;
        logic div_done;
        logic rounds_done;
        logic word_last;
        logic block_last;
        logic below_floor;
    } t_sts;

endpackage

// ===== rtl/ccker_ram.sv =====
module ccker_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ccker_ctrl.sv =====
module ccker_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ccker_pkg::t_sts i_sts,
    output ccker_pkg::t_cmd o_cmd,
    output ccker_pkg::t_state o_state
);

    ccker_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    ccker_pkg::t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccker_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            ccker_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    cmd.seed    = !i_sts.seeded;
                    n_state     = ccker_pkg::S_DISPATCH;
                end
            end
            ccker_pkg::S_DISPATCH: begin
                if (i_sts.action == ccker_pkg::ACTION_RAW) begin
                    n_state = ccker_pkg::S_DRAW;
                end else if (i_sts.bound_small) begin
                    cmd.value_zero = 1'b1;
                    n_state        = ccker_pkg::S_DONE;
                end else begin
                    cmd.div_floor = 1'b1;
                    n_state       = ccker_pkg::S_FLOOR;
                end
            end
            ccker_pkg::S_FLOOR: begin
                if (i_sts.div_done) begin
                    cmd.floor_ld = 1'b1;
                    n_state      = ccker_pkg::S_DRAW;
                end
            end
            ccker_pkg::S_DRAW: begin
                if (i_sts.words_empty) begin
                    n_state = ccker_pkg::S_BLK_INIT;
                end else begin
                    cmd.read_word = 1'b1;
                    n_state       = ccker_pkg::S_RDWAIT;
                end
            end
            ccker_pkg::S_RDWAIT: begin
                if (i_sts.action == ccker_pkg::ACTION_RAW) begin
                    cmd.value_word = 1'b1;
                    n_state        = ccker_pkg::S_DONE;
                end else if (i_sts.below_floor) begin
                    n_state = ccker_pkg::S_DRAW;
                end else begin
                    cmd.div_word = 1'b1;
                    n_state      = ccker_pkg::S_MOD;
                end
            end
            ccker_pkg::S_MOD: begin
                if (i_sts.div_done) begin
                    cmd.value_rem = 1'b1;
                    n_state       = ccker_pkg::S_DONE;
                end
            end
            ccker_pkg::S_BLK_INIT: begin
                cmd.blk_init = 1'b1;
                n_state      = ccker_pkg::S_ROUND;
            end
            ccker_pkg::S_ROUND: begin
                cmd.round_step = 1'b1;
                if (i_sts.rounds_done) begin
                    n_state = ccker_pkg::S_FINAL;
                end
            end
            ccker_pkg::S_FINAL: begin
                cmd.final_add = 1'b1;
                n_state       = ccker_pkg::S_WRITE;
            end
            ccker_pkg::S_WRITE: begin
                cmd.write_word = 1'b1;
                if (i_sts.word_last) begin
                    if (i_sts.block_last) begin
                        cmd.rekey = 1'b1;
                        n_state   = ccker_pkg::S_DRAW;
                    end else begin
                        cmd.next_block = 1'b1;
                        n_state        = ccker_pkg::S_BLK_INIT;
                    end
                end
            end
            ccker_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_ld = 1'b1;
                    n_state    = ccker_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ccker_pkg::S_IDLE;
            end
        endcase

        if (cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_state     = r_state;
    assign o_in_ready  = (r_state == ccker_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/ccker_dpath.sv =====
module ccker_dpath #(
    parameter int BLOCKS_PER_REFILL = ccker_pkg::BLOCKS_PER_REFILL_DEF,
    parameter int DOUBLE_ROUNDS     = ccker_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ccker_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    input  logic                           i_action,
    input  logic [31:0]                    i_bound,
    input  ccker_pkg::t_cmd                i_cmd,
    output ccker_pkg::t_sts                o_sts,
    output logic [31:0]                    o_value
);

    localparam int STORE_WORDS = BLOCKS_PER_REFILL * 16;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int WL_W        = $clog2(STORE_WORDS + 1);
    localparam int BLK_W       = (BLOCKS_PER_REFILL > 1) ? $clog2(BLOCKS_PER_REFILL) : 1;
    localparam int STEPS       = DOUBLE_ROUNDS * 8;
    localparam int STEP_W      = $clog2(STEPS);

    logic [63:0]       r_seed [5];
    logic              r_seeded;
    logic              r_action;
    logic [31:0]       r_bound;
    logic [31:0]       r_floor;
    logic [31:0]       r_value;
    logic [31:0]       r_out;
    logic [31:0]       r_key [8];
    logic [31:0]       r_pkey [8];
    logic [63:0]       r_nonce, r_pnonce;
    logic [63:0]       r_ctr;
    logic [31:0]       r_w [16];
    logic [STEP_W-1:0] r_step;
    logic [3:0]        r_wj;
    logic [BLK_W-1:0]  r_blk;
    logic [WL_W-1:0]   r_words_left;
    logic [31:0]       r_div_x;
    logic [31:0]       r_rem;
    logic [5:0]        r_div_cnt;

    logic [31:0]       init_w [16];
    logic [31:0]       n_round [16];
    logic [31:0]       sum_w [16];
    logic [31:0]       rdata;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [BLK_W+3:0]  waddr_full;
    logic [32:0]       div_t;
    logic [32:0]       div_d;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init_w[i] = ccker_pkg::SIGMA[i];
        end
        for (int i = 0; i < 8; i++) begin
            init_w[4 + i] = r_key[i];
        end
        init_w[12] = r_ctr[31:0];
        init_w[13] = r_ctr[63:32];
        init_w[14] = r_nonce[31:0];
        init_w[15] = r_nonce[63:32];
        for (int i = 0; i < 16; i++) begin
            sum_w[i] = r_w[i] + init_w[i];
        end
    end

    // one add/xor/rotate sub-step of all four quarter rounds per cycle
    always_comb begin
        logic [1:0]  li, ob, oc, od;
        logic        diag;
        int          ia, ib, ic, id;
        logic [31:0] s, x;
        n_round = r_w;
        diag    = r_step[2];
        for (int i = 0; i < 4; i++) begin
            li = 2'(i);
            ob = li + {1'b0, diag};
            oc = li + {diag, 1'b0};
            od = li + {diag, diag};
            ia = i;
            ib = 4 + int'(ob);
            ic = 8 + int'(oc);
            id = 12 + int'(od);
            case (r_step[1:0])
                2'd0: begin
                    s = n_round[ia] + n_round[ib];
                    x = n_round[id] ^ s;
                    n_round[ia] = s;
                    n_round[id] = {x[15:0], x[31:16]};
                end
                2'd1: begin
                    s = n_round[ic] + n_round[id];
                    x = n_round[ib] ^ s;
                    n_round[ic] = s;
                    n_round[ib] = {x[19:0], x[31:20]};
                end
                2'd2: begin
                    s = n_round[ia] + n_round[ib];
                    x = n_round[id] ^ s;
                    n_round[ia] = s;
                    n_round[id] = {x[23:0], x[31:24]};
                end
                default: begin
                    s = n_round[ic] + n_round[id];
                    x = n_round[ib] ^ s;
                    n_round[ic] = s;
                    n_round[ib] = {x[24:0], x[31:25]};
                end
            endcase
        end
    end

    assign div_d = {1'b0, r_bound};
    assign div_t = {r_rem, r_div_x[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_seed[i] <= '0;
            end
            r_seeded     <= 1'b0;
            r_words_left <= '0;
            r_div_cnt    <= '0;
            r_step       <= '0;
            r_wj         <= '0;
            r_blk        <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == ccker_pkg::REG_KEY_LOW)    r_seed[0] <= i_cfg_data;
                if (i_cfg_index == ccker_pkg::REG_KEY_SECOND) r_seed[1] <= i_cfg_data;
                if (i_cfg_index == ccker_pkg::REG_KEY_THIRD)  r_seed[2] <= i_cfg_data;
                if (i_cfg_index == ccker_pkg::REG_KEY_HIGH)   r_seed[3] <= i_cfg_data;
                if (i_cfg_index == ccker_pkg::REG_NONCE)      r_seed[4] <= i_cfg_data;
            end

            if (i_cmd.seed) begin
                r_seeded     <= 1'b1;
                r_words_left <= '0;
                r_blk        <= '0;
            end else if (i_cmd.rekey) begin
                r_words_left <= WL_W'(STORE_WORDS - ccker_pkg::REKEY_WORDS);
                r_blk        <= '0;
            end else if (i_cmd.read_word) begin
                r_words_left <= r_words_left - 1'b1;
            end else if (i_cmd.next_block) begin
                r_blk <= r_blk + 1'b1;
            end

            if (i_cmd.div_floor || i_cmd.div_word) begin
                r_div_cnt <= 6'd32;
            end else if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end

            if (i_cmd.blk_init) begin
                r_step <= '0;
                r_wj   <= '0;
            end else begin
                if (i_cmd.round_step) r_step <= r_step + 1'b1;
                if (i_cmd.write_word) r_wj   <= r_wj + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_bound  <= i_bound;
        end

        if (i_cmd.seed) begin
            for (int i = 0; i < 4; i++) begin
                r_key[2 * i]     <= r_seed[i][31:0];
                r_key[2 * i + 1] <= r_seed[i][63:32];
            end
            r_nonce <= r_seed[4];
            r_ctr   <= '0;
        end else if (i_cmd.rekey) begin
            r_key   <= r_pkey;
            r_nonce <= r_pnonce;
            r_ctr   <= '0;
        end else if (i_cmd.next_block) begin
            r_ctr <= r_ctr + 64'd1;
        end

        if (i_cmd.blk_init) begin
            r_w <= init_w;
        end else if (i_cmd.round_step) begin
            r_w <= n_round;
        end else if (i_cmd.final_add) begin
            r_w <= sum_w;
        end

        // first block of a refill carries the next key and nonce
        if (i_cmd.final_add && r_blk == '0) begin
            for (int i = 0; i < 8; i++) begin
                r_pkey[i] <= sum_w[i];
            end
            r_pnonce <= {sum_w[9], sum_w[8]};
        end

        if (i_cmd.div_floor) begin
            r_div_x <= 32'd0 - r_bound;
            r_rem   <= '0;
        end else if (i_cmd.div_word) begin
            r_div_x <= rdata;
            r_rem   <= '0;
        end else if (r_div_cnt != '0) begin
            r_div_x <= {r_div_x[30:0], 1'b0};
            if (div_t >= div_d) begin
                r_rem <= 32'(div_t - div_d);
            end else begin
                r_rem <= div_t[31:0];
            end
        end

        if (i_cmd.floor_ld) r_floor <= r_rem;

        if (i_cmd.value_zero) begin
            r_value <= '0;
        end else if (i_cmd.value_word) begin
            r_value <= rdata;
        end else if (i_cmd.value_rem) begin
            r_value <= r_rem;
        end

        if (i_cmd.out_ld) r_out <= r_value;
    end

    assign raddr      = ADDR_W'(WL_W'(STORE_WORDS) - r_words_left);
    assign waddr_full = {r_blk, r_wj};
    assign waddr      = waddr_full[ADDR_W-1:0];

    ccker_ram #(
        .WIDTH (32),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write_word),
        .i_waddr (waddr),
        .i_wdata (r_w[r_wj]),
        .i_re    (i_cmd.read_word),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_sts.seeded      = r_seeded;
        o_sts.action      = r_action;
        o_sts.bound_small = (r_bound < 32'd2);
        o_sts.words_empty = (r_words_left == '0);
        o_sts.div_done    = (r_div_cnt == '0);
        o_sts.rounds_done = (r_step == STEP_W'(STEPS - 1));
        o_sts.word_last   = (r_wj == 4'd15);
        o_sts.block_last  = (r_blk == BLK_W'(BLOCKS_PER_REFILL - 1));
        o_sts.below_floor = (rdata < r_floor);
    end

    assign o_value = r_out;

endmodule

// ===== rtl/chacha_key_erasure_random_source.sv =====
// channel  direction  beat payload
// s        in         tuser: action; tdata: bound[31:0]
// m        out        tdata: value[31:0]
// cfg      in         index[2:0], data[63:0]; always ready
//
// Raw request from a filled store: states dispatch, draw, read-wait, then done.
// Uniform request also runs the serial remainder unit for the floor and once per
// accepted word; each rejected word is dropped and another word is drawn.
// Empty store: a refill first writes BLOCKS_PER_REFILL blocks to the store, with one
// quarter-round sub-step per cycle and one store write per cycle.
// Sync reset; seed taken on the first beat; a new beat is taken while a result waits.
module chacha_key_erasure_random_source #(
    parameter int BLOCKS_PER_REFILL = ccker_pkg::BLOCKS_PER_REFILL_DEF,
    parameter int DOUBLE_ROUNDS     = ccker_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] bound
    input  logic                            s_tuser,   // [0] action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [31:0] value
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ccker_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                     i_cfg_data
);

    ccker_pkg::t_cmd   w_cmd;
    ccker_pkg::t_sts   w_sts;
    ccker_pkg::t_state w_state;

    assign o_cfg_ready = 1'b1;

    ccker_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    ccker_dpath #(
        .BLOCKS_PER_REFILL (BLOCKS_PER_REFILL),
        .DOUBLE_ROUNDS     (DOUBLE_ROUNDS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_action    (s_tuser),
        .i_bound     (s_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_value     (m_tdata)
    );

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.read_word |-> !w_sts.words_empty)
        else $error("store read with no words left");

    a_rekey_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rekey |-> (w_sts.block_last && w_sts.word_last))
        else $error("rekey before last block written");

    a_rem_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.value_rem || w_cmd.floor_ld) |-> w_sts.div_done)
        else $error("remainder taken before divider finished");

    a_refill_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == ccker_pkg::S_DRAW && w_sts.words_empty) |=>
            (w_state == ccker_pkg::S_BLK_INIT))
        else $error("empty store did not start a refill");

endmodule
